@@ hw/rtl/peh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge hysteresis package
// Shared widths, register codes, reset values and types of the
// potentiometer edge hysteresis block.
// ----------------------------------------------------------------------------
package peh_pkg;

   // Sizing
   localparam int CHANNELS   = 16;
   localparam int ADC_BITS   = 10;
   localparam int CHAN_W     = 4;
   localparam int SUM_W      = 15;
   localparam int SHIFT_W    = 3;
   localparam int LEVEL_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int FULL_SCALE = (ADC_BITS >= LEVEL_W) ? (2 ** LEVEL_W) - 1
                                                     : (2 ** ADC_BITS) - 1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_SHIFT    = 3'd0,
      CSR_UPPER_THRESHOLD = 3'd1,
      CSR_LOWER_THRESHOLD = 3'd2,
      CSR_UPPER_BOOST     = 3'd3,
      CSR_LOWER_CUT       = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [SHIFT_W-1:0] SAMPLE_SHIFT_RST    = 3'd3;
   localparam logic [LEVEL_W-1:0] UPPER_THRESHOLD_RST = 10'd1000;
   localparam logic [LEVEL_W-1:0] LOWER_THRESHOLD_RST = 10'd20;
   localparam logic [LEVEL_W-1:0] UPPER_BOOST_RST     = 10'd20;
   localparam logic [LEVEL_W-1:0] LOWER_CUT_RST       = 10'd20;

   typedef struct packed {
      logic [SHIFT_W-1:0] sample_shift;
      logic [LEVEL_W-1:0] upper_threshold;
      logic [LEVEL_W-1:0] lower_threshold;
      logic [LEVEL_W-1:0] upper_boost;
      logic [LEVEL_W-1:0] lower_cut;
   } cfg_type;

   // Per-channel hysteresis flags
   typedef struct packed {
      logic low_active;
      logic high_active;
   } flags_type;

endpackage

@@ hw/rtl/peh_cond.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge hysteresis conditioning
// Turns one accumulated sum into a level and decides the new flags of
// its channel from the old ones.
// ----------------------------------------------------------------------------
module peh_cond (
   input  peh_pkg::cfg_type                       cfg,
   input  logic [peh_pkg::SUM_W-1:0]              sample_sum,
   input  peh_pkg::flags_type                     flags_old,
   output peh_pkg::flags_type                     flags_new,
   output logic [peh_pkg::LEVEL_W-1:0]            level
);

   localparam int WIDE_W = peh_pkg::SUM_W + 1;

   logic [peh_pkg::SUM_W-1:0]   avg;
   logic [WIDE_W-1:0]           avg_wide;
   logic [WIDE_W-1:0]           boost_sum;
   logic [WIDE_W-1:0]           low_band_top;
   logic [peh_pkg::LEVEL_W-1:0] boosted;
   logic [peh_pkg::LEVEL_W-1:0] cut;
   logic [peh_pkg::LEVEL_W-1:0] plain;
   logic                        above_upper;
   logic                        below_dead_band;
   logic                        below_lower;
   logic                        in_low_band;

   // Average and the compares against the bands
   assign avg          = cfg.sample_shift == '0 ? sample_sum : sample_sum >> cfg.sample_shift;
   assign avg_wide     = {1'b0, avg};
   assign boost_sum    = avg_wide + WIDE_W'(cfg.upper_boost);
   assign low_band_top = WIDE_W'(cfg.lower_threshold) + WIDE_W'(cfg.lower_cut);

   assign above_upper     = avg_wide > WIDE_W'(cfg.upper_threshold);
   assign below_dead_band = boost_sum < WIDE_W'(cfg.upper_threshold);
   assign below_lower     = avg_wide < WIDE_W'(cfg.lower_threshold);
   assign in_low_band     = avg_wide < low_band_top;

   // Candidate outputs: saturate boost at full scale, clamp cut at zero
   assign boosted = (boost_sum > WIDE_W'(peh_pkg::FULL_SCALE))
                    ? peh_pkg::LEVEL_W'(peh_pkg::FULL_SCALE)
                    : boost_sum[peh_pkg::LEVEL_W-1:0];
   assign cut     = (avg >= peh_pkg::SUM_W'(cfg.lower_cut))
                    ? peh_pkg::LEVEL_W'(avg - peh_pkg::SUM_W'(cfg.lower_cut))
                    : '0;
   assign plain   = avg[peh_pkg::LEVEL_W-1:0];

   // Pick level and next flags
   always_comb begin
      flags_new = flags_old;
      level     = plain;
      if (above_upper) begin
         flags_new.high_active = 1'b1;
         flags_new.low_active  = 1'b0;
         level                 = boosted;
      end else if (below_dead_band) begin
         flags_new.high_active = 1'b0;
         if (below_lower) begin
            flags_new.low_active = 1'b1;
            level                = cut;
         end else if (in_low_band) begin
            level = flags_old.low_active ? cut : plain;
         end else begin
            flags_new.low_active = 1'b0;
         end
      end else begin
         level = flags_old.high_active ? boosted : plain;
      end
   end

endmodule

@@ hw/rtl/pot_edge_hysteresis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potentiometer edge hysteresis
// Conditions per-channel averaged ADC readings near the ends of travel.
// ----------------------------------------------------------------------------
// One word in, one level out. A word is registered on entry, conditioned
// against that channel's flag pair while it sits in the input stage, and
// lands in the output register together with the updated flags when it
// moves on, so a word can enter every cycle while the output is not stalled.
// The flags live in flip-flops and are read and rewritten in the same
// cycle, so a word for the same channel right behind sees the updated
// flags. The input keeps taking words while a result waits, until both
// stages are full. Registers are to be written by the user only while no
// word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pot_edge_hysteresis (
   input  logic                               clock,
   input  logic                               reset,
   // Input words
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [peh_pkg::CHAN_W-1:0]         req_channel,
   input  logic [peh_pkg::SUM_W-1:0]          req_sample_sum,
   // Result words
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [peh_pkg::LEVEL_W-1:0]        rsp_level,
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [peh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [peh_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CHAN_CMP_W = 8;

   peh_pkg::cfg_type                   cfg_ff;
   logic                               s1_valid_ff;
   logic [peh_pkg::CHAN_W-1:0]         s1_channel_ff;
   logic [peh_pkg::SUM_W-1:0]          s1_sum_ff;
   logic                               rsp_valid_ff;
   logic [peh_pkg::LEVEL_W-1:0]        rsp_level_ff;
   logic [peh_pkg::CHANNELS-1:0]       low_active_ff;
   logic [peh_pkg::CHANNELS-1:0]       high_active_ff;
   logic [peh_pkg::CHANNELS-1:0]       low_active_in;
   logic [peh_pkg::CHANNELS-1:0]       high_active_in;

   logic                               advance;
   logic                               move;
   logic                               accept;
   logic                               chan_ok;
   peh_pkg::flags_type                 flags_old;
   peh_pkg::flags_type                 flags_new;
   logic [peh_pkg::LEVEL_W-1:0]        level;

   // Handshakes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign move      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_shift    <= peh_pkg::SAMPLE_SHIFT_RST;
         cfg_ff.upper_threshold <= peh_pkg::UPPER_THRESHOLD_RST;
         cfg_ff.lower_threshold <= peh_pkg::LOWER_THRESHOLD_RST;
         cfg_ff.upper_boost     <= peh_pkg::UPPER_BOOST_RST;
         cfg_ff.lower_cut       <= peh_pkg::LOWER_CUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (peh_pkg::csr_index_type'(csr_index))
            peh_pkg::CSR_SAMPLE_SHIFT: begin
               cfg_ff.sample_shift <= csr_wdata[peh_pkg::SHIFT_W-1:0];
            end
            peh_pkg::CSR_UPPER_THRESHOLD: begin
               cfg_ff.upper_threshold <= csr_wdata;
            end
            peh_pkg::CSR_LOWER_THRESHOLD: begin
               cfg_ff.lower_threshold <= csr_wdata;
            end
            peh_pkg::CSR_UPPER_BOOST: begin
               cfg_ff.upper_boost <= csr_wdata;
            end
            peh_pkg::CSR_LOWER_CUT: begin
               cfg_ff.lower_cut <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Capture input word; load whenever the stage is empty or moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (accept) begin
         s1_channel_ff <= req_channel;
         s1_sum_ff     <= req_sample_sum;
      end
   end

   // Look up the channel's flags; unknown channels read as clear
   assign chan_ok = CHAN_CMP_W'(s1_channel_ff) < CHAN_CMP_W'(peh_pkg::CHANNELS);

   always_comb begin
      flags_old.low_active  = chan_ok && low_active_ff[s1_channel_ff];
      flags_old.high_active = chan_ok && high_active_ff[s1_channel_ff];
   end

   peh_cond u_cond (
      .cfg        (cfg_ff),
      .sample_sum (s1_sum_ff),
      .flags_old  (flags_old),
      .flags_new  (flags_new),
      .level      (level)
   );

   // Write back the flags of the channel that moves on
   always_comb begin
      low_active_in  = low_active_ff;
      high_active_in = high_active_ff;
      for (int i = 0; i < peh_pkg::CHANNELS; i++) begin
         if (move && chan_ok && (int'(s1_channel_ff) == i)) begin
            low_active_in[i]  = flags_new.low_active;
            high_active_in[i] = flags_new.high_active;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_active_ff  <= '0;
         high_active_ff <= '0;
      end else begin
         low_active_ff  <= low_active_in;
         high_active_ff <= high_active_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (move) begin
         rsp_level_ff <= level;
      end
   end

   // Checks
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      (low_active_ff & high_active_ff) == '0)
      else $error("channel has both flags set");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(low_active_ff) && $stable(high_active_ff))
      else $error("flags changed without a word moving");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages are full");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= peh_pkg::LEVEL_W'(peh_pkg::FULL_SCALE))
      else $error("level above full scale");

endmodule
